// ===== hdl/sric_pkg.sv =====
`timescale 1ns / 1ps
package sric_pkg;

  localparam int EDGES = 4;
  // touch points plus crossings, at most EDGES
  localparam int CNT_W = 4;
  localparam logic [1:0] COUNT_MAX = 2'd2;

  // sign of a cross product or difference
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  // load enables of a two-stage section
  typedef struct packed {
    logic ld_a;
    logic ld_b;
  } ld2_t;

  function automatic sgn_t sgn_mul(input sgn_t s, input sgn_t t);
    sgn_t r;
    r.zero = s.zero | t.zero;
    r.neg  = ~r.zero & (s.neg ^ t.neg);
    return r;
  endfunction

  function automatic sgn_t sgn_inv(input sgn_t s);
    sgn_t r;
    r.zero = s.zero;
    r.neg  = ~s.zero & ~s.neg;
    return r;
  endfunction

  // both nonzero with equal sign
  function automatic logic same_side(input sgn_t s, input sgn_t t);
    return ~s.zero & ~t.zero & (s.neg == t.neg);
  endfunction

endpackage

// ===== hdl/sric_front.sv =====
`timescale 1ns / 1ps
// Stage 1: differences and edge-side signs. Stage 2: corner cross-product terms.
module sric_front #(
  parameter int W = 16
) (
  input  logic                     clk,
  input  sric_pkg::ld2_t           ld,
  input  logic [8*W-1:0]           din,
  output logic signed [2*W+1:0]    p1 [sric_pkg::EDGES],
  output logic signed [2*W+1:0]    p2 [sric_pkg::EDGES],
  output sric_pkg::sgn_t           o3 [sric_pkg::EDGES],
  output sric_pkg::sgn_t           o4 [sric_pkg::EDGES],
  output logic [8*W-1:0]           crd
);

  logic signed [W-1:0] lx, by, rx, ty, ax, ay, bx, bq;
  logic signed [W:0]   sdx_nxt, sdy_nxt, uxl_nxt, uxr_nxt, vyt_nxt, vyb_nxt;
  logic signed [W:0]   sdx_r, sdy_r, uxl_r, uxr_r, vyt_r, vyb_r;
  sric_pkg::sgn_t      s_tb, s_rl;
  sric_pkg::sgn_t      o3_nxt [sric_pkg::EDGES];
  sric_pkg::sgn_t      o4_nxt [sric_pkg::EDGES];
  sric_pkg::sgn_t      o3_r [sric_pkg::EDGES];
  sric_pkg::sgn_t      o4_r [sric_pkg::EDGES];
  logic [8*W-1:0]      crd_r;

  function automatic sric_pkg::sgn_t cmp_sgn(input logic signed [W-1:0] x,
                                             input logic signed [W-1:0] y);
    sric_pkg::sgn_t r;
    r.zero = (x == y);
    r.neg  = (x < y);
    return r;
  endfunction

  assign lx = din[0*W +: W];
  assign by = din[1*W +: W];
  assign rx = din[2*W +: W];
  assign ty = din[3*W +: W];
  assign ax = din[4*W +: W];
  assign ay = din[5*W +: W];
  assign bx = din[6*W +: W];
  assign bq = din[7*W +: W];

  assign sdx_nxt = {bx[W-1], bx} - {ax[W-1], ax};
  assign sdy_nxt = {bq[W-1], bq} - {ay[W-1], ay};
  assign uxl_nxt = {lx[W-1], lx} - {ax[W-1], ax};
  assign uxr_nxt = {rx[W-1], rx} - {ax[W-1], ax};
  assign vyt_nxt = {ty[W-1], ty} - {ay[W-1], ay};
  assign vyb_nxt = {by[W-1], by} - {ay[W-1], ay};

  assign s_tb = cmp_sgn(ty, by);
  assign s_rl = cmp_sgn(rx, lx);

  // axis-aligned edges: orientation of an endpoint is a product of two signs
  always_comb begin
    o3_nxt[0] = sric_pkg::sgn_mul(s_tb, cmp_sgn(ax, lx));
    o4_nxt[0] = sric_pkg::sgn_mul(s_tb, cmp_sgn(bx, lx));
    o3_nxt[1] = sric_pkg::sgn_mul(s_rl, cmp_sgn(ay, by));
    o4_nxt[1] = sric_pkg::sgn_mul(s_rl, cmp_sgn(bq, by));
    o3_nxt[2] = sric_pkg::sgn_inv(sric_pkg::sgn_mul(s_tb, cmp_sgn(ax, rx)));
    o4_nxt[2] = sric_pkg::sgn_inv(sric_pkg::sgn_mul(s_tb, cmp_sgn(bx, rx)));
    o3_nxt[3] = sric_pkg::sgn_inv(sric_pkg::sgn_mul(s_rl, cmp_sgn(ay, ty)));
    o4_nxt[3] = sric_pkg::sgn_inv(sric_pkg::sgn_mul(s_rl, cmp_sgn(bq, ty)));
  end

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      sdx_r  <= sdx_nxt;
      sdy_r  <= sdy_nxt;
      uxl_r  <= uxl_nxt;
      uxr_r  <= uxr_nxt;
      vyt_r  <= vyt_nxt;
      vyb_r  <= vyb_nxt;
      o3_r   <= o3_nxt;
      o4_r   <= o4_nxt;
      crd_r  <= din;
    end
  end

  // corners: 0 left/top, 1 left/bottom, 2 right/bottom, 3 right/top
  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      p1[0] <= sdx_r * vyt_r;
      p2[0] <= sdy_r * uxl_r;
      p1[1] <= sdx_r * vyb_r;
      p2[1] <= sdy_r * uxl_r;
      p1[2] <= sdx_r * vyb_r;
      p2[2] <= sdy_r * uxr_r;
      p1[3] <= sdx_r * vyt_r;
      p2[3] <= sdy_r * uxr_r;
      o3    <= o3_r;
      o4    <= o4_r;
      crd   <= crd_r;
    end
  end

endmodule

// ===== hdl/sric_edge.sv =====
`timescale 1ns / 1ps
// Stage 3: corner orientation signs. Stage 4: per-edge classification.
module sric_edge #(
  parameter int W = 16
) (
  input  logic                   clk,
  input  sric_pkg::ld2_t         ld,
  input  logic signed [2*W+1:0]  p1 [sric_pkg::EDGES],
  input  logic signed [2*W+1:0]  p2 [sric_pkg::EDGES],
  input  sric_pkg::sgn_t         o3 [sric_pkg::EDGES],
  input  sric_pkg::sgn_t         o4 [sric_pkg::EDGES],
  input  logic [8*W-1:0]         crd,
  output logic                   inf_any,
  output logic [sric_pkg::EDGES-1:0] hv,
  output logic [2*W-1:0]         hit [sric_pkg::EDGES],
  output logic [sric_pkg::EDGES-1:0] cv,
  output logic [8*W-1:0]         crd_o
);

  localparam int PW = 2 * W;

  sric_pkg::sgn_t ok_r [sric_pkg::EDGES];
  sric_pkg::sgn_t o3_r [sric_pkg::EDGES];
  sric_pkg::sgn_t o4_r [sric_pkg::EDGES];
  logic [8*W-1:0] crd_r;
  logic [PW-1:0]  kp [sric_pkg::EDGES];
  logic [PW-1:0]  pa, pb, sl, sh;
  logic [sric_pkg::EDGES-1:0] inf_e, hv_e, cv_e;
  logic [PW-1:0]  hit_e [sric_pkg::EDGES];

  // lexicographic (x, y) less-than; points packed as {x, y}
  function automatic logic pt_lt(input logic [PW-1:0] p, input logic [PW-1:0] q);
    logic signed [W-1:0] px, py, qx, qy;
    px = p[PW-1:W];
    py = p[W-1:0];
    qx = q[PW-1:W];
    qy = q[W-1:0];
    return (px < qx) || ((px == qx) && (py < qy));
  endfunction

  always_ff @(posedge clk) begin
    if (ld.ld_a) begin
      for (int k = 0; k < sric_pkg::EDGES; k++) begin
        logic signed [2*W+2:0] cr;
        cr = {p1[k][2*W+1], p1[k]} - {p2[k][2*W+1], p2[k]};
        ok_r[k].zero <= (cr == '0);
        ok_r[k].neg  <= cr[2*W+2];
      end
      o3_r  <= o3;
      o4_r  <= o4;
      crd_r <= crd;
    end
  end

  assign kp[0] = {crd_r[0*W +: W], crd_r[3*W +: W]};
  assign kp[1] = {crd_r[0*W +: W], crd_r[1*W +: W]};
  assign kp[2] = {crd_r[2*W +: W], crd_r[1*W +: W]};
  assign kp[3] = {crd_r[2*W +: W], crd_r[3*W +: W]};
  assign pa    = {crd_r[4*W +: W], crd_r[5*W +: W]};
  assign pb    = {crd_r[6*W +: W], crd_r[7*W +: W]};
  assign sl    = pt_lt(pb, pa) ? pb : pa;
  assign sh    = pt_lt(pb, pa) ? pa : pb;

  for (genvar g = 0; g < sric_pkg::EDGES; g++) begin : g_edge
    localparam int GN = (g + 1) % sric_pkg::EDGES;
    logic [PW-1:0] el, eh, lo, hi;
    logic col;

    assign el  = pt_lt(kp[GN], kp[g]) ? kp[GN] : kp[g];
    assign eh  = pt_lt(kp[GN], kp[g]) ? kp[g] : kp[GN];
    assign lo  = pt_lt(sl, el) ? el : sl;
    assign hi  = pt_lt(eh, sh) ? eh : sh;
    assign col = ok_r[g].zero & ok_r[GN].zero & o3_r[g].zero & o4_r[g].zero;

    always_comb begin
      inf_e[g] = 1'b0;
      hv_e[g]  = 1'b0;
      cv_e[g]  = 1'b0;
      hit_e[g] = kp[g];
      if (col) begin
        // collinear: overlap of positive length, or a single shared point
        inf_e[g] = pt_lt(lo, hi);
        hv_e[g]  = (lo == hi);
        hit_e[g] = lo;
      end else if (!sric_pkg::same_side(ok_r[g], ok_r[GN]) &&
                   !sric_pkg::same_side(o3_r[g], o4_r[g])) begin
        if (ok_r[g].zero) begin
          hv_e[g] = 1'b1;
        end else if (ok_r[GN].zero) begin
          hv_e[g]  = 1'b1;
          hit_e[g] = kp[GN];
        end else begin
          cv_e[g] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld_b) begin
      inf_any <= |inf_e;
      hv      <= hv_e;
      hit     <= hit_e;
      cv      <= cv_e;
      crd_o   <= crd_r;
    end
  end

endmodule

// ===== hdl/sric_count.sv =====
`timescale 1ns / 1ps
// Stage 5: merge duplicate points, count, clamp; output register.
module sric_count #(
  parameter int W = 16
) (
  input  logic                       clk,
  input  logic                       ld,
  input  logic                       inf_any,
  input  logic [sric_pkg::EDGES-1:0] hv,
  input  logic [2*W-1:0]             hit [sric_pkg::EDGES],
  input  logic [sric_pkg::EDGES-1:0] cv,
  input  logic [8*W-1:0]             crd,
  output logic [1:0]                 point_count_r,
  output logic                       infinite_r
);

  logic [2*W-1:0]             kp [sric_pkg::EDGES];
  logic [sric_pkg::CNT_W-1:0] total;
  logic [1:0]                 cnt_nxt;

  assign kp[0] = {crd[0*W +: W], crd[3*W +: W]};
  assign kp[1] = {crd[0*W +: W], crd[1*W +: W]};
  assign kp[2] = {crd[2*W +: W], crd[1*W +: W]};
  assign kp[3] = {crd[2*W +: W], crd[3*W +: W]};

  // crossings are identified by the edge's unordered endpoint pair
  always_comb begin
    logic dup_h, dup_c, same;
    int   in_, jn;
    total = '0;
    for (int i = 0; i < sric_pkg::EDGES; i++) begin
      dup_h = 1'b0;
      dup_c = 1'b0;
      in_   = (i + 1) % sric_pkg::EDGES;
      for (int j = 0; j < sric_pkg::EDGES; j++) begin
        jn   = (j + 1) % sric_pkg::EDGES;
        same = ((kp[i] == kp[j]) && (kp[in_] == kp[jn])) ||
               ((kp[i] == kp[jn]) && (kp[in_] == kp[j]));
        if (j < i) begin
          if (hv[j] && (hit[j] == hit[i])) dup_h = 1'b1;
          if (cv[j] && same)               dup_c = 1'b1;
        end
      end
      total = total + {{(sric_pkg::CNT_W-1){1'b0}}, hv[i] & ~dup_h}
                    + {{(sric_pkg::CNT_W-1){1'b0}}, cv[i] & ~dup_c};
    end
    if (inf_any) begin
      cnt_nxt = '0;
    end else if (total > {{(sric_pkg::CNT_W-2){1'b0}}, sric_pkg::COUNT_MAX}) begin
      cnt_nxt = sric_pkg::COUNT_MAX;
    end else begin
      cnt_nxt = total[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      point_count_r <= cnt_nxt;
      infinite_r    <= inf_any;
    end
  end

endmodule

// ===== hdl/segment_rectangle_intersection_count.sv =====
`timescale 1ns / 1ps
// Pipeline: 5 register stages; out_tvalid rises when the accepted item reaches the last of them.
// Throughput: 1 item per cycle while out_tready is high; each stage fills when empty or when the next moves.
// Reset (rst_n low, synchronous): all stage valid bits clear, output goes idle.
// Datapath registers are not reset.
// Stall: out_tready low holds the result; earlier stages keep filling bubbles.
module segment_rectangle_intersection_count #(
  parameter int COORD_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // fields low to high: rect_left, rect_bottom, rect_right, rect_top,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y
  input  logic [8*COORD_BITS-1:0] in_tdata,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // fields low to high: point_count [1:0], zero fill [7:2]
  output logic [7:0]              out_tdata,
  // fields: infinite
  output logic                    out_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready
);

  localparam int W = COORD_BITS;

  // Stages in order: differences/edge signs, products, corner signs,
  // edge classification, dedup/count (output register).
  logic [4:0]       v_r;
  logic [5:1]       ld;
  sric_pkg::ld2_t   ld_f, ld_e;

  logic signed [2*W+1:0] p1 [sric_pkg::EDGES];
  logic signed [2*W+1:0] p2 [sric_pkg::EDGES];
  sric_pkg::sgn_t        o3 [sric_pkg::EDGES];
  sric_pkg::sgn_t        o4 [sric_pkg::EDGES];
  logic [8*W-1:0]        crd2, crd4;
  logic                  inf_any;
  logic [sric_pkg::EDGES-1:0] hv, cv;
  logic [2*W-1:0]        hit [sric_pkg::EDGES];
  logic [1:0]            point_count_r;
  logic                  infinite_r;

  // a stage loads when empty or when its successor loads
  assign ld[5] = ~v_r[4] | out_tready;
  assign ld[4] = ~v_r[3] | ld[5];
  assign ld[3] = ~v_r[2] | ld[4];
  assign ld[2] = ~v_r[1] | ld[3];
  assign ld[1] = ~v_r[0] | ld[2];

  assign in_tready = ld[1];
  assign ld_f = '{ld_a: ld[1], ld_b: ld[2]};
  assign ld_e = '{ld_a: ld[3], ld_b: ld[4]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[1]) v_r[0] <= in_tvalid;
      if (ld[2]) v_r[1] <= v_r[0];
      if (ld[3]) v_r[2] <= v_r[1];
      if (ld[4]) v_r[3] <= v_r[2];
      if (ld[5]) v_r[4] <= v_r[3];
    end
  end

  sric_front #(.W(W)) u_front (
    .clk (clk),
    .ld  (ld_f),
    .din (in_tdata),
    .p1  (p1),
    .p2  (p2),
    .o3  (o3),
    .o4  (o4),
    .crd (crd2)
  );

  sric_edge #(.W(W)) u_edge (
    .clk     (clk),
    .ld      (ld_e),
    .p1      (p1),
    .p2      (p2),
    .o3      (o3),
    .o4      (o4),
    .crd     (crd2),
    .inf_any (inf_any),
    .hv      (hv),
    .hit     (hit),
    .cv      (cv),
    .crd_o   (crd4)
  );

  sric_count #(.W(W)) u_count (
    .clk           (clk),
    .ld            (ld[5]),
    .inf_any       (inf_any),
    .hv            (hv),
    .hit           (hit),
    .cv            (cv),
    .crd           (crd4),
    .point_count_r (point_count_r),
    .infinite_r    (infinite_r)
  );

  assign out_tvalid = v_r[4];
  assign out_tdata  = {6'b0, point_count_r};
  assign out_tuser  = infinite_r;

endmodule

// ===== hdl/sric_chk.sv =====
`timescale 1ns / 1ps
module sric_chk (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_tready,
  input logic [7:0]              out_tdata,
  input logic                    out_tuser,
  input logic                    out_tvalid,
  input logic                    out_tready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result dropped or changed while stalled");

  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[1:0] == 2'd0)
    else $error("count nonzero with infinite set");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:2] == 6'd0 && out_tdata[1:0] != 2'd3)
    else $error("count out of range");

  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind segment_rectangle_intersection_count sric_chk u_chk (.*);
